// ===== rtl/srlt_pkg.sv =====
// ----------------------------------------------------------------------------
// srlt_pkg: shared types and codes of the sorted range list table
// Command and status codes, the entry word and the per-cell control types.
// ----------------------------------------------------------------------------
package srlt_pkg;

  localparam int unsigned VAL_W   = 31;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_POP    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_PLACED = 3'd0,
    ST_MERGED = 3'd1,
    ST_FULL   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_DONE   = 3'd4
  } status_t;

  typedef struct packed {
    logic [VAL_W-1:0] run;
    logic [VAL_W-1:0] first;
    logic [VAL_W-1:0] last;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } cell_word_t;

  // What one cell does at the next edge.
  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_LOAD,
    ACT_FROM_LEFT,
    ACT_FROM_RIGHT,
    ACT_MERGE,
    ACT_CLEAR
  } cell_act_t;

  // Compare results a cell reports against the broadcast key.
  typedef struct packed {
    logic stop;   // insert walk ends here (or the cell is empty)
    logic merge;  // the key range overlaps this entry of the same run
    logic match;  // entry belongs to the key run
  } cell_flag_t;

endpackage

// ===== rtl/srlt_if.sv =====
// ----------------------------------------------------------------------------
// srlt_req_if / srlt_rsp_if: command and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface srlt_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic [30:0]               run_number;
  logic [30:0]               range_first;
  logic [30:0]               range_last;

  modport source (output valid, command, run_number, range_first, range_last,
                  input ready);
  modport sink   (input valid, command, run_number, range_first, range_last,
                  output ready);
endinterface

interface srlt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        head_valid;
  logic [30:0] head_run;
  logic [30:0] head_first;
  logic [30:0] head_last;
  logic [6:0]  removed_count;
  logic [6:0]  entry_count;

  modport source (output valid, status, head_valid, head_run, head_first, head_last,
                  removed_count, entry_count, input ready);
  modport sink   (input valid, status, head_valid, head_run, head_first, head_last,
                  removed_count, entry_count, output ready);
endinterface

// ===== rtl/sorted_range_list_table.sv =====
// ----------------------------------------------------------------------------
// sorted_range_list_table: sorted table of run event ranges
// A row of CAPACITY cells kept sorted by run, then by first event.
// ----------------------------------------------------------------------------
// Usage: commands arrive on req (insert, remove run, pop head, clear); every
// command yields exactly one word on rsp with a status, the popped head, the
// removed count and the entry count after the command.
// A command is taken only while the table is idle. The cells compare the
// command against every entry at once and the row shifts by one slot per
// cycle while rsp is not stalled. Insert, pop and clear load the result
// register in their execute step and the table then returns to idle to
// accept the next command. Remove deletes one matching entry per cycle while
// rsp is not stalled and loads the result once no matching entry is left.
// The result sits in an output register; while rsp is stalled the finished
// command waits there, one more command can be accepted, and that command
// waits before it executes until the pending result word leaves.
// Reset (synchronous, active high) empties the table at once through the
// per-cell valid bits and drops any pending result.
// ----------------------------------------------------------------------------
module sorted_range_list_table #(
  parameter int unsigned CAPACITY = 64
) (
  input logic      clk,
  input logic      rst,
  srlt_req_if.sink   req,
  srlt_rsp_if.source rsp
);
  import srlt_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t            state;
  cmd_t              cmd;
  entry_t            key;
  logic [CNT_W-1:0]  occupancy;
  logic [CNT_W-1:0]  occupancy_next;
  logic [CNT_W-1:0]  removed;

  cell_word_t        words [CAPACITY];
  cell_flag_t        flags [CAPACITY];
  cell_act_t         acts  [CAPACITY];

  logic [CAPACITY:0] seen_stop;
  logic [CAPACITY:0] seen_match;
  logic              any_merge;
  logic              full;
  logic              step;
  logic              finish;
  status_t           status_next;

  localparam cell_word_t EMPTY_WORD = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_word_t left_w;
    cell_word_t right_w;
    if (i == 0) begin : g_first
      assign left_w = EMPTY_WORD;
    end else begin : g_mid
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = EMPTY_WORD;
    end else begin : g_inner
      assign right_w = words[i+1];
    end
    srlt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .act   (acts[i]),
      .key   (key),
      .left  (left_w),
      .right (right_w),
      .word  (words[i]),
      .flags (flags[i])
    );
  end

  // Prefix of "some earlier cell already stopped / matched".
  always_comb begin
    seen_stop[0]  = 1'b0;
    seen_match[0] = 1'b0;
    any_merge     = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      seen_stop[i+1]  = seen_stop[i] | flags[i].stop;
      seen_match[i+1] = seen_match[i] | flags[i].match;
      any_merge       = any_merge | (flags[i].stop & ~seen_stop[i] & flags[i].merge);
    end
  end

  assign full   = occupancy == CNT_W'(CAPACITY);
  assign step   = (state == S_EXEC) && (!rsp.valid || rsp.ready);
  assign finish = step && !((cmd == CMD_REMOVE) && seen_match[CAPACITY]);

  always_comb begin
    occupancy_next = occupancy;
    status_next    = ST_DONE;
    for (int i = 0; i < CAPACITY; i++) acts[i] = ACT_HOLD;
    if (step) begin
      case (cmd)
        CMD_INSERT: begin
          if (any_merge) begin
            status_next = ST_MERGED;
            for (int i = 0; i < CAPACITY; i++)
              if (flags[i].stop && !seen_stop[i]) acts[i] = ACT_MERGE;
          end else if (full) begin
            status_next = ST_FULL;
          end else begin
            status_next    = ST_PLACED;
            occupancy_next = occupancy + 1'b1;
            for (int i = 0; i < CAPACITY; i++) begin
              if (seen_stop[i]) acts[i] = ACT_FROM_LEFT;
              else if (flags[i].stop) acts[i] = ACT_LOAD;
            end
          end
        end
        CMD_REMOVE: begin
          if (seen_match[CAPACITY]) begin
            occupancy_next = occupancy - 1'b1;
            for (int i = 0; i < CAPACITY; i++)
              if (seen_match[i+1]) acts[i] = ACT_FROM_RIGHT;
          end
        end
        CMD_POP: begin
          if (occupancy == '0) begin
            status_next = ST_EMPTY;
          end else begin
            occupancy_next = occupancy - 1'b1;
            for (int i = 0; i < CAPACITY; i++) acts[i] = ACT_FROM_RIGHT;
          end
        end
        default: begin
          occupancy_next = '0;
          for (int i = 0; i < CAPACITY; i++) acts[i] = ACT_CLEAR;
        end
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (finish) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
      occupancy <= occupancy_next;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd       <= cmd_t'(req.command);
            key.run   <= req.run_number;
            key.first <= req.range_first;
            key.last  <= req.range_last;
            removed   <= '0;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (step && !finish) removed <= removed + 1'b1;
          if (finish) begin
            state             <= S_IDLE;
            rsp.status        <= status_next;
            rsp.entry_count   <= COUNT_W'(occupancy_next);
            rsp.removed_count <= (cmd == CMD_REMOVE) ? COUNT_W'(removed) : '0;
            if ((cmd == CMD_POP) && (occupancy != '0)) begin
              rsp.head_valid <= 1'b1;
              rsp.head_run   <= words[0].entry.run;
              rsp.head_first <= words[0].entry.first;
              rsp.head_last  <= words[0].entry.last;
            end else begin
              rsp.head_valid <= 1'b0;
              rsp.head_run   <= '0;
              rsp.head_first <= '0;
              rsp.head_last  <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/srlt_cell.sv =====
// ----------------------------------------------------------------------------
// srlt_cell: one slot of the sorted table
// Holds one entry, compares it with the broadcast key and loads, merges,
// clears or takes a neighbor's word as the chain controller tells it.
// ----------------------------------------------------------------------------
module srlt_cell (
  input  logic                clk,
  input  logic                rst,
  input  srlt_pkg::cell_act_t act,
  input  srlt_pkg::entry_t    key,
  input  srlt_pkg::cell_word_t left,
  input  srlt_pkg::cell_word_t right,
  output srlt_pkg::cell_word_t word,
  output srlt_pkg::cell_flag_t flags
);
  import srlt_pkg::*;

  logic same_run;
  logic below;
  logic past;

  assign same_run = word.entry.run == key.run;
  // The key range lies wholly below this entry.
  assign below = (key.first < word.entry.first) && (key.last < word.entry.first);
  assign past  = key.first > word.entry.last;

  always_comb begin
    flags.match = word.valid && same_run;
    flags.merge = word.valid && same_run && !below && !past;
    flags.stop  = !word.valid || (word.entry.run > key.run) ||
                  (same_run && (below || !past));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word.valid <= 1'b0;
    end else begin
      case (act)
        ACT_LOAD: begin
          word.valid <= 1'b1;
          word.entry <= key;
        end
        ACT_FROM_LEFT:  word <= left;
        ACT_FROM_RIGHT: word <= right;
        ACT_MERGE: begin
          if (key.first < word.entry.first) word.entry.first <= key.first;
          if (key.last > word.entry.last) word.entry.last <= key.last;
        end
        ACT_CLEAR: word.valid <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/srlt_checker.sv =====
// ----------------------------------------------------------------------------
// srlt_checker: port-level checks of the sorted range list table
// Watches the result channel for consistent status and field combinations.
// ----------------------------------------------------------------------------
module srlt_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] status,
  input logic       head_valid,
  input logic [6:0] removed_count,
  input logic [6:0] entry_count
);
  import srlt_pkg::*;

  // A popped entry is always reported with the done status.
  a_head_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && head_valid |-> status == ST_DONE)
    else $error("head returned without done status");

  // An empty pop leaves an empty table and no head.
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_EMPTY) |-> (entry_count == '0) && !head_valid)
    else $error("empty pop with entries or head");

  // Removal counts come only with the done status and never with a head.
  a_removed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (removed_count != '0) |-> (status == ST_DONE) && !head_valid)
    else $error("removed count on wrong result");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry_count))
    else $error("stalled result changed");

endmodule

bind sorted_range_list_table srlt_checker u_srlt_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .head_valid    (rsp.head_valid),
  .removed_count (rsp.removed_count),
  .entry_count   (rsp.entry_count)
);
